FILE: hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared constants, codes and item types for the allocator block.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int POOL_ORDER_DEF = 12;
  localparam int FIELD_W        = 13;
  localparam int REQ_ORD_W      = 4;
  localparam int OUT_ORD_W      = 4;

  // order used for a zero-byte request
  localparam logic [REQ_ORD_W-1:0] ZERO_ORDER = 4'd4;

  typedef enum logic [0:0] {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  typedef struct packed {
    logic               action;
    logic [FIELD_W-1:0] request_size;
    logic [FIELD_W-1:0] user_offset;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0]   granted_offset;
    status_t              status;
    logic [OUT_ORD_W-1:0] granted_order;
  } rsp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ctl_stat_t;

endpackage

FILE: hdl/bba_stream_if.sv
// ----------------------------------------------------------------------------
// Buddy block allocator stream interface
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface bba_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/bba_ram.sv
// ----------------------------------------------------------------------------
// Buddy block allocator RAM
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy block allocator sequencer
// Walks the header RAM to allocate, split, unlink, merge and push blocks.
// ----------------------------------------------------------------------------
module bba_ctrl #(
  parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  bba_pkg::req_t    req,
  input  logic             take,
  output bba_pkg::rsp_t    rsp,
  output bba_pkg::ctl_stat_t stat
);
  import bba_pkg::*;

  localparam int IDX_W = POOL_ORDER - 1;
  localparam int DEPTH = 1 << IDX_W;
  localparam int NL    = POOL_ORDER + 1;
  localparam int OW    = $clog2(POOL_ORDER + 1);

  typedef struct packed {
    logic             occ;
    logic [OW-1:0]    ord;
    logic             has_next;
    logic             has_prev;
    logic [IDX_W-1:0] nxt;
    logic [IDX_W-1:0] prv;
  } hdr_t;

  localparam int HW = $bits(hdr_t);

  typedef enum logic [17:0] {
    S_IDLE   = 18'b000000000000000001,
    S_DEC    = 18'b000000000000000010,
    S_URD    = 18'b000000000000000100,
    S_UL     = 18'b000000000000001000,
    S_PRD    = 18'b000000000000010000,
    S_PWR    = 18'b000000000000100000,
    S_NRD    = 18'b000000000001000000,
    S_NWR    = 18'b000000000010000000,
    S_ULDONE = 18'b000000000100000000,
    S_MTEST  = 18'b000000001000000000,
    S_FRD    = 18'b000000010000000000,
    S_FCHK   = 18'b000000100000000000,
    S_PUSH   = 18'b000001000000000000,
    S_PNWR   = 18'b000010000000000000,
    S_PHWR   = 18'b000100000000000000,
    S_SPLIT  = 18'b001000000000000000,
    S_AFIN   = 18'b010000000000000000,
    S_DONE   = 18'b100000000000000000
  } state_t;

  state_t state;

  logic               is_free;
  logic [FIELD_W-1:0] size_q;
  logic [FIELD_W-1:0] off_q;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   tgt;
  logic [IDX_W-1:0]   pidx;
  logic [OW-1:0]      korder;
  logic [OW-1:0]      lvl;
  logic [OW-1:0]      pord;
  hdr_t               hdr;
  rsp_t               rsp_q;

  // free list heads
  logic [NL-1:0]    head_v;
  logic [IDX_W-1:0] head_idx [NL];

  // entry 0 holds its reset header until first written
  logic init0;
  logic rd0;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  hdr_t             wtmp;
  logic [HW-1:0]    ram_q;
  hdr_t             hv;
  hdr_t             rst_hdr;

  logic             hw_en;
  logic [OW-1:0]    hw_k;
  logic             hw_v;
  logic [IDX_W-1:0] hw_idx;

  logic [OW-1:0]    hsel;
  logic             hsel_v;
  logic [IDX_W-1:0] hsel_idx;

  logic [REQ_ORD_W-1:0] kreq;
  logic                 too_big;
  logic                 found;
  logic [OW-1:0]        jsel;
  logic [FIELD_W-1:0]   bofs;
  logic                 bad_off;
  logic                 ord_ok;
  logic [IDX_W-1:0]     amask;
  logic                 align_ok;
  logic                 no_merge;

  bba_ram #(
    .WIDTH (HW),
    .DEPTH (DEPTH)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wtmp),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // substitute the reset header for entry 0
  always_comb begin
    rst_hdr     = '0;
    rst_hdr.ord = OW'(POOL_ORDER);
  end
  assign hv = rd0 ? rst_hdr : hdr_t'(ram_q);

  // single head read port
  assign hsel     = (state == S_DEC) ? jsel : pord;
  assign hsel_v   = head_v[hsel];
  assign hsel_idx = head_idx[hsel];

  // request order and free list search
  always_comb begin
    kreq = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      if (size_q[i]) kreq = REQ_ORD_W'(i + 1);
    end
    if (size_q == '0) kreq = ZERO_ORDER;
  end
  assign too_big = int'(kreq) > POOL_ORDER;

  always_comb begin
    found = 1'b0;
    jsel  = '0;
    for (int i = NL - 1; i >= 0; i--) begin
      if (head_v[i] && i >= int'(kreq)) begin
        found = 1'b1;
        jsel  = OW'(i);
      end
    end
  end

  // free offset checks
  assign bofs    = off_q - 1'b1;
  assign bad_off = (off_q == '0) || bofs[0] || (int'(bofs) >= (1 << POOL_ORDER));

  assign ord_ok   = (hv.ord != '0) && (int'(hv.ord) <= POOL_ORDER);
  assign amask    = (hv.ord == '0) ? '0 : IDX_W'((32'd1 << (hv.ord - 1'b1)) - 32'd1);
  assign align_ok = (idx & amask) == '0;

  // buddy is not a free block of the same order
  assign no_merge = is_free && (hv.occ || hv.ord != korder);

  function automatic logic [OW-1:0] list_of(input logic [OW-1:0] o);
    return (int'(o) < NL) ? o : '0;
  endfunction

  // RAM and head port control
  always_comb begin
    we     = 1'b0;
    waddr  = '0;
    raddr  = '0;
    wtmp   = hv;
    hw_en  = 1'b0;
    hw_k   = '0;
    hw_v   = 1'b0;
    hw_idx = '0;
    case (state)
      S_URD: raddr = tgt;
      S_FRD: raddr = idx;
      S_PRD: raddr = hdr.prv;
      S_NRD: raddr = hdr.nxt;
      S_PUSH: raddr = hsel_idx;
      S_FCHK: begin
        // mark the freed block as no longer occupied
        if (hv.occ && ord_ok && align_ok) begin
          we       = 1'b1;
          waddr    = idx;
          wtmp.occ = 1'b0;
        end
      end
      S_UL: begin
        if (!no_merge && !hv.has_prev) begin
          hw_en  = 1'b1;
          hw_k   = list_of(hv.ord);
          hw_v   = hv.has_next;
          hw_idx = hv.nxt;
        end
      end
      S_PWR: begin
        we            = 1'b1;
        waddr         = hdr.prv;
        wtmp.has_next = hdr.has_next;
        wtmp.nxt      = hdr.nxt;
      end
      S_NWR: begin
        we            = 1'b1;
        waddr         = hdr.nxt;
        wtmp.has_prev = hdr.has_prev;
        wtmp.prv      = hdr.prv;
      end
      S_PNWR: begin
        we            = 1'b1;
        waddr         = hsel_idx;
        wtmp.has_prev = 1'b1;
        wtmp.prv      = pidx;
      end
      S_PHWR: begin
        we            = 1'b1;
        waddr         = pidx;
        wtmp.occ      = 1'b0;
        wtmp.ord      = pord;
        wtmp.has_next = hsel_v;
        wtmp.has_prev = 1'b0;
        wtmp.nxt      = hsel_idx;
        wtmp.prv      = '0;
        hw_en         = 1'b1;
        hw_k          = pord;
        hw_v          = 1'b1;
        hw_idx        = pidx;
      end
      S_AFIN: begin
        we            = 1'b1;
        waddr         = idx;
        wtmp.occ      = 1'b1;
        wtmp.ord      = korder;
        wtmp.has_next = 1'b0;
        wtmp.has_prev = 1'b0;
        wtmp.nxt      = hdr.nxt;
        wtmp.prv      = hdr.prv;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head_v <= {1'b1, {(NL-1){1'b0}}};
      for (int i = 0; i < NL; i++) head_idx[i] <= '0;
      init0  <= 1'b1;
      rd0    <= 1'b0;
    end else begin
      rd0 <= init0 && (raddr == '0);
      if (we && waddr == '0) init0 <= 1'b0;
      if (hw_en) begin
        head_v[hw_k]   <= hw_v;
        head_idx[hw_k] <= hw_idx;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            is_free <= (req.action == ACT_FREE);
            size_q  <= req.request_size;
            off_q   <= req.user_offset;
            state   <= S_DEC;
          end
        end
        S_DEC: begin
          if (!is_free) begin
            if (too_big || !found) begin
              rsp_q <= '{granted_offset: '0, status: ST_NOSPACE, granted_order: '0};
              state <= S_DONE;
            end else begin
              idx    <= hsel_idx;
              tgt    <= hsel_idx;
              lvl    <= jsel;
              korder <= OW'(kreq);
              state  <= S_URD;
            end
          end else if (bad_off) begin
            rsp_q <= '{granted_offset: '0, status: ST_BADFREE, granted_order: '0};
            state <= S_DONE;
          end else begin
            idx   <= IDX_W'(bofs[FIELD_W-1:1]);
            state <= S_FRD;
          end
        end
        S_URD: state <= S_UL;
        S_UL: begin
          if (no_merge) begin
            pidx  <= idx;
            pord  <= korder;
            state <= S_PUSH;
          end else begin
            hdr <= hv;
            if (hv.has_prev)      state <= S_PRD;
            else if (hv.has_next) state <= S_NRD;
            else                  state <= S_ULDONE;
          end
        end
        S_PRD: state <= S_PWR;
        S_PWR: state <= hdr.has_next ? S_NRD : S_ULDONE;
        S_NRD: state <= S_NWR;
        S_NWR: state <= S_ULDONE;
        S_ULDONE: begin
          if (is_free) begin
            if (tgt < idx) idx <= tgt;
            korder <= korder + 1'b1;
            state  <= S_MTEST;
          end else begin
            state <= S_SPLIT;
          end
        end
        S_MTEST: begin
          if (int'(korder) < POOL_ORDER) begin
            tgt   <= idx ^ IDX_W'(32'd1 << (korder - 1'b1));
            state <= S_URD;
          end else begin
            pidx  <= idx;
            pord  <= korder;
            state <= S_PUSH;
          end
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (!hv.occ || !ord_ok || !align_ok) begin
            rsp_q <= '{granted_offset: '0, status: ST_BADFREE, granted_order: '0};
            state <= S_DONE;
          end else begin
            korder <= hv.ord;
            state  <= S_MTEST;
          end
        end
        S_PUSH: state <= hsel_v ? S_PNWR : S_PHWR;
        S_PNWR: state <= S_PHWR;
        S_PHWR: begin
          if (is_free) begin
            rsp_q <= '{granted_offset: FIELD_W'({pidx, 1'b1}), status: ST_OK,
                       granted_order: OUT_ORD_W'(pord)};
            state <= S_DONE;
          end else begin
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          if (lvl > korder) begin
            pidx  <= idx + IDX_W'(32'd1 << (lvl - 2'd2));
            pord  <= lvl - 1'b1;
            lvl   <= lvl - 1'b1;
            state <= S_PUSH;
          end else begin
            state <= S_AFIN;
          end
        end
        S_AFIN: begin
          rsp_q <= '{granted_offset: FIELD_W'({idx, 1'b1}), status: ST_OK,
                     granted_order: OUT_ORD_W'(korder)};
          state <= S_DONE;
        end
        S_DONE: begin
          if (take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp       = rsp_q;
  assign stat.busy = (state != S_IDLE);
  assign stat.done = (state == S_DONE);

endmodule

FILE: hdl/buddy_block_allocator_top.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Allocates and frees power-of-two blocks of a pool, one request at a time.
// ----------------------------------------------------------------------------
// Throughput: one item at a time; each header access goes through the header
// RAM's single read port, so the next item enters once the result has
// moved into the output register.
// Reset: synchronous; the whole pool is one free block, no clearing pass.
module buddy_block_allocator_top #(
  parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF
) (
  input logic         clk,
  input logic         rst,
  bba_stream_if.sink   req,
  bba_stream_if.source rsp
);
  import bba_pkg::*;

  ctl_stat_t stat;
  rsp_t      ctl_rsp;
  logic      start;
  logic      take;
  logic      out_v;
  rsp_t      out_d;

  assign req.ready = !stat.busy;
  assign start     = req.valid && req.ready;
  assign take      = !out_v || rsp.ready;

  bba_ctrl #(
    .POOL_ORDER (POOL_ORDER)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req.data),
    .take  (take),
    .rsp   (ctl_rsp),
    .stat  (stat)
  );

  // hold the finished item until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (stat.done && take) begin
      out_v <= 1'b1;
    end else if (rsp.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && take) begin
      out_d <= ctl_rsp;
    end
  end

  assign rsp.valid = out_v;
  assign rsp.data  = out_d;

  // a failed request carries no offset and no order
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_v && out_d.status != ST_OK |-> out_d.granted_offset == '0 &&
                                       out_d.granted_order == '0)
    else $error("failed item carries offset or order");

  // a granted offset always points past the one-byte header
  a_ok_odd: assert property (@(posedge clk) disable iff (rst)
    out_v && out_d.status == ST_OK |-> out_d.granted_offset[0])
    else $error("granted offset is even");

  // an accepted item keeps the sequencer busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> !req.ready)
    else $error("ready after accept");

  // a finished item is loaded into the output register
  a_load: assert property (@(posedge clk) disable iff (rst)
    stat.done && take |=> out_v)
    else $error("finished item dropped");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Runs directed and random allocate/free requests through the allocator with
// random stalls on both channels. The expected results come from a buddy-pool
// model kept in this file, and each result is checked against them in order.
// ----------------------------------------------------------------------------
module testbench;
  import bba_pkg::*;

  localparam int PORD  = POOL_ORDER_DEF;
  localparam int NSLOT = 1 << (PORD - 1);
  localparam int NLIST = PORD + 1;

  logic clk;
  logic rst;

  bba_stream_if #(.T(req_t)) req_ch ();
  bba_stream_if #(.T(rsp_t)) rsp_ch ();

  buddy_block_allocator_top #(.POOL_ORDER(PORD)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // pool model: slot headers and free list heads
  logic        slot_used [NSLOT];
  logic [3:0]  slot_ord  [NSLOT];
  logic        slot_hn   [NSLOT];
  logic        slot_hp   [NSLOT];
  logic [10:0] slot_nx   [NSLOT];
  logic [10:0] slot_pv   [NSLOT];
  bit          slot_seen [NSLOT];
  logic        head_vld  [NLIST];
  logic [10:0] head_idx  [NLIST];

  req_t        pending_reqs [$];
  rsp_t        expected_rsps [$];
  logic [12:0] live_offsets [$];
  logic [12:0] last_freed;
  int          errors;
  bit          idle_on;
  int          req_gap, rsp_gap, draw;

  function automatic int list_of(logic [3:0] o);
    return (o < NLIST) ? int'(o) : 0;
  endfunction

  function automatic void pool_reset();
    for (int i = 0; i < NSLOT; i++) begin
      slot_used[i] = 0; slot_ord[i] = 0; slot_hn[i] = 0; slot_hp[i] = 0;
      slot_nx[i] = 0; slot_pv[i] = 0; slot_seen[i] = 0;
    end
    for (int i = 0; i < NLIST; i++) begin
      head_vld[i] = 0; head_idx[i] = 0;
    end
    slot_ord[0] = 4'(PORD);
    slot_seen[0] = 1;
    head_vld[PORD] = 1;
  endfunction

  function automatic void unlink_slot(logic [10:0] idx);
    int k;
    k = list_of(slot_ord[idx]);
    if (slot_hp[idx]) begin
      slot_hn[slot_pv[idx]] = slot_hn[idx];
      slot_nx[slot_pv[idx]] = slot_nx[idx];
    end else begin
      head_vld[k] = slot_hn[idx];
      head_idx[k] = slot_nx[idx];
    end
    if (slot_hn[idx]) begin
      slot_hp[slot_nx[idx]] = slot_hp[idx];
      slot_pv[slot_nx[idx]] = slot_pv[idx];
    end
    slot_hn[idx] = 0;
    slot_hp[idx] = 0;
  endfunction

  function automatic void push_slot(logic [10:0] idx, int o);
    int k;
    k = list_of(o[3:0]);
    slot_seen[idx] = 1;
    slot_used[idx] = 0;
    slot_ord[idx] = o[3:0];
    slot_hp[idx] = 0;
    slot_pv[idx] = 0;
    slot_hn[idx] = head_vld[k];
    slot_nx[idx] = head_idx[k];
    if (head_vld[k]) begin
      slot_hp[head_idx[k]] = 1;
      slot_pv[head_idx[k]] = idx;
    end
    head_vld[k] = 1;
    head_idx[k] = idx;
  endfunction

  // compute the result of one request and advance the pool model
  function automatic rsp_t pool_step(req_t r);
    rsp_t res;
    int k, j, b;
    logic [10:0] idx, bud;
    res.granted_offset = '0;
    res.status = ST_NOSPACE;
    res.granted_order = '0;
    if (r.action == ACT_ALLOC) begin
      if (r.request_size == 0) k = int'(ZERO_ORDER);
      else begin
        k = 0;
        while (k < 14 && (1 << k) <= r.request_size) k++;
      end
      if (k > PORD) return res;
      for (j = k; j <= PORD; j++) if (head_vld[j]) break;
      if (j > PORD) return res;
      idx = head_idx[j];
      unlink_slot(idx);
      for (int l = j; l > k; l--) push_slot(idx + 11'(1 << (l - 2)), l - 1);
      slot_used[idx] = 1;
      slot_ord[idx] = k[3:0];
      slot_hn[idx] = 0;
      slot_hp[idx] = 0;
      slot_seen[idx] = 1;
      res.granted_offset = 13'({idx, 1'b1});
      res.status = ST_OK;
      res.granted_order = k[3:0];
      return res;
    end
    res.status = ST_BADFREE;
    if (r.user_offset == 0) return res;
    b = int'(r.user_offset) - 1;
    if (b >= (1 << PORD) || b[0]) return res;
    idx = b[11:1];
    k = int'(slot_ord[idx]);
    if (!slot_used[idx] || k < 1 || k > PORD || (b & ((1 << k) - 1)) != 0) return res;
    slot_used[idx] = 0;
    while (k < PORD) begin
      bud = idx ^ 11'(1 << (k - 1));
      if (slot_used[bud] || int'(slot_ord[bud]) != k) break;
      unlink_slot(bud);
      if (bud < idx) idx = bud;
      k++;
    end
    push_slot(idx, k);
    res.granted_offset = 13'({idx, 1'b1});
    res.status = ST_OK;
    res.granted_order = k[3:0];
    return res;
  endfunction

  // a free whose header read the pool has defined
  function automatic bit free_is_defined(logic [12:0] uoff);
    int b;
    if (uoff == 0) return 1;
    b = int'(uoff) - 1;
    if (b >= (1 << PORD) || b[0]) return 1;
    return slot_seen[b[11:1]];
  endfunction

  task automatic queue_item(logic act, logic [12:0] size, logic [12:0] uoff);
    req_t r;
    rsp_t e;
    r.action = act;
    r.request_size = size;
    r.user_offset = uoff;
    e = pool_step(r);
    pending_reqs.push_back(r);
    expected_rsps.push_back(e);
    if (e.status == ST_OK) begin
      if (act == ACT_ALLOC) live_offsets.push_back(e.granted_offset);
      else begin
        last_freed = uoff;
        foreach (live_offsets[i])
          if (live_offsets[i] == uoff) begin
            live_offsets.delete(i);
            break;
          end
      end
    end
  endtask

  task automatic free_live(int pos);
    queue_item(ACT_FREE, 13'($urandom), live_offsets[pos]);
  endtask

  // clock
  initial clk = 0;
  always #6 clk = ~clk;

  function automatic int draw_gap();
    return idle_on ? $urandom_range(0, 8) : 0;
  endfunction

  // drive requests from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 0;
      req_gap <= 0;
    end else if (req_ch.valid && !req_ch.ready) begin
      // hold the item until it is taken
    end else if (req_gap > 0) begin
      req_ch.valid <= 0;
      req_gap <= req_gap - 1;
    end else if (pending_reqs.size() > 0) begin
      req_ch.valid <= 1;
      req_ch.data <= pending_reqs.pop_front();
      req_gap <= draw_gap();
    end else begin
      req_ch.valid <= 0;
    end
  end

  // accept and check results
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 0;
      rsp_gap <= 0;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, rsp_ch.data);
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        if (rsp_ch.data.granted_offset !== e.granted_offset) begin
          errors++;
          $display("%0t: granted_offset expected %0d actual %0d", $time,
                   e.granted_offset, rsp_ch.data.granted_offset);
        end
        if (rsp_ch.data.status !== e.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time,
                   e.status, rsp_ch.data.status);
        end
        if (rsp_ch.data.granted_order !== e.granted_order) begin
          errors++;
          $display("%0t: granted_order expected %0d actual %0d", $time,
                   e.granted_order, rsp_ch.data.granted_order);
        end
      end
      draw = draw_gap();
      rsp_gap <= draw;
      rsp_ch.ready <= (draw == 0);
    end else if (rsp_gap > 0) begin
      rsp_gap <= rsp_gap - 1;
      rsp_ch.ready <= (rsp_gap == 1);
    end else begin
      rsp_ch.ready <= 1;
    end
  end

  // stimulus and end of run
  initial begin
    logic [12:0] cand;
    int sel;
    errors = 0;
    idle_on = 0;
    last_freed = 0;
    req_ch.valid = 0;
    req_ch.data = '0;
    rsp_ch.ready = 0;
    rst = 1;
    pool_reset();

    // directed: zero size, smallest block, oversize, bad frees, merging
    queue_item(ACT_ALLOC, 0, 0);
    queue_item(ACT_ALLOC, 1, 8191);
    queue_item(ACT_ALLOC, 5000, 0);
    queue_item(ACT_ALLOC, 8191, 0);
    queue_item(ACT_FREE, 0, 0);
    queue_item(ACT_FREE, 0, 8191);
    queue_item(ACT_FREE, 0, 4097);
    queue_item(ACT_FREE, 0, 2);
    cand = live_offsets[0];
    free_live(0);
    queue_item(ACT_FREE, 0, cand);
    free_live(0);
    queue_item(ACT_ALLOC, 4095, 0);
    queue_item(ACT_ALLOC, 1, 0);
    free_live(0);
    queue_item(ACT_ALLOC, 4096, 0);
    queue_item(ACT_ALLOC, 2047, 0);
    queue_item(ACT_ALLOC, 2047, 0);
    queue_item(ACT_ALLOC, 0, 0);
    free_live(1);
    free_live(0);
    queue_item(ACT_ALLOC, 100, 0);
    queue_item(ACT_ALLOC, 3, 0);
    free_live(0);
    free_live(0);

    // random: mostly valid alloc/free traffic, a share of bad frees
    for (int n = 0; n < 1530; n++) begin
      if (n % 97 == 0) idle_on = $urandom_range(0, 3) != 0;
      sel = $urandom_range(0, 99);
      if (live_offsets.size() > 40) sel = 60;
      if (live_offsets.size() == 0 && sel >= 55 && sel < 92) sel = 0;
      if (sel < 55) begin
        sel = $urandom_range(0, 99);
        if (sel < 80) cand = 13'($urandom_range(0, 64));
        else if (sel < 95) cand = 13'($urandom_range(0, 1024));
        else cand = 13'($urandom_range(0, 8191));
        queue_item(ACT_ALLOC, cand, 13'($urandom));
      end else if (sel < 92) begin
        free_live($urandom_range(0, live_offsets.size() - 1));
      end else begin
        case ($urandom_range(0, 4))
          0: cand = 0;
          1: cand = 13'($urandom_range(0, 2047) * 2);
          2: cand = 13'($urandom_range(4097, 8191));
          3: cand = last_freed;
          default: cand = 13'($urandom_range(0, 2047) * 2 + 1);
        endcase
        if (!free_is_defined(cand)) cand = 0;
        queue_item(ACT_FREE, 13'($urandom), cand);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 0;
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_ch.valid)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

FILE: filelist.f
hdl/bba_pkg.sv
hdl/bba_stream_if.sv
hdl/bba_ram.sv
hdl/bba_ctrl.sv
hdl/buddy_block_allocator_top.sv
tb/sv/testbench.sv
